// ===== rtl/pse_pkg.sv =====
package pse_pkg;

	// Widths of the external fields.
	localparam int OUT_TIME_W    = 17;
	localparam int STEP_W        = 16;
	localparam int KEY_W         = 3;
	localparam int SEL_W         = 2;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 17;
	localparam int TIME_BITS_DEF = 17;

	// Key codes.
	localparam logic [KEY_W-1:0] KEY_NONE = 3'd0;
	localparam logic [KEY_W-1:0] KEY_DOWN = 3'd1;
	localparam logic [KEY_W-1:0] KEY_UP   = 3'd2;
	localparam logic [KEY_W-1:0] KEY_PREV = 3'd3;
	localparam logic [KEY_W-1:0] KEY_NEXT = 3'd4;

	// Selectable fields.
	localparam logic [SEL_W-1:0] SEL_PULSE  = 2'd0;
	localparam logic [SEL_W-1:0] SEL_PERIOD = 2'd1;
	localparam logic [SEL_W-1:0] SEL_PULSE2 = 2'd2;
	localparam logic [SEL_W-1:0] SEL_STEP   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_FLOOR  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_CEIL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_FLOOR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_CEIL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FINE_STEP    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COARSE_STEP  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SAVE_DELAY   = 3'd6;

	// Reset values of the configuration registers.
	localparam logic [STEP_W-1:0]     RST_PULSE_FLOOR  = 16'd500;
	localparam logic [OUT_TIME_W-1:0] RST_PULSE_CEIL   = 17'd99500;
	localparam logic [OUT_TIME_W-1:0] RST_PERIOD_FLOOR = 17'd10000;
	localparam logic [OUT_TIME_W-1:0] RST_PERIOD_CEIL  = 17'd100000;
	localparam logic [STEP_W-1:0]     RST_FINE_STEP    = 16'd100;
	localparam logic [STEP_W-1:0]     RST_COARSE_STEP  = 16'd1000;
	localparam logic [STEP_W-1:0]     RST_SAVE_DELAY   = 16'd1000;

	// Reset values of the edited settings.
	localparam int RST_PULSE  = 1000;
	localparam int RST_PERIOD = 50000;
	localparam int RST_PULSE2 = 2000;

	typedef struct packed {
		logic [STEP_W-1:0]     pulse_floor;
		logic [OUT_TIME_W-1:0] pulse_ceil;
		logic [OUT_TIME_W-1:0] period_floor;
		logic [OUT_TIME_W-1:0] period_ceil;
		logic [STEP_W-1:0]     fine_step;
		logic [STEP_W-1:0]     coarse_step;
		logic [STEP_W-1:0]     save_delay;
	} cfg_t;

	typedef struct packed {
		logic [OUT_TIME_W-1:0] pulse_ns;
		logic [OUT_TIME_W-1:0] period_ns;
		logic [OUT_TIME_W-1:0] pulse2_ns;
		logic [STEP_W-1:0]     step_ns;
		logic [SEL_W-1:0]      selected_field;
		logic                  values_changed;
		logic                  save_strobe;
	} result_t;

endpackage

// ===== rtl/pse_key_if.sv =====
interface pse_key_if import pse_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] key_code;

	modport source (output valid, output key_code, input ready);
	modport sink (input valid, input key_code, output ready);
endinterface

// ===== rtl/pse_set_if.sv =====
interface pse_set_if import pse_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [OUT_TIME_W-1:0] pulse_ns;
	logic [OUT_TIME_W-1:0] period_ns;
	logic [OUT_TIME_W-1:0] pulse2_ns;
	logic [STEP_W-1:0]     step_ns;
	logic [SEL_W-1:0]      selected_field;
	logic                  values_changed;
	logic                  save_strobe;

	modport source (output valid, output pulse_ns, output period_ns, output pulse2_ns,
		output step_ns, output selected_field, output values_changed, output save_strobe,
		input ready);
	modport sink (input valid, input pulse_ns, input period_ns, input pulse2_ns,
		input step_ns, input selected_field, input values_changed, input save_strobe,
		output ready);
endinterface

// ===== rtl/pse_cfg_regs.sv =====
module pse_cfg_regs import pse_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register file; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_floor  <= RST_PULSE_FLOOR;
			cfg_q.pulse_ceil   <= RST_PULSE_CEIL;
			cfg_q.period_floor <= RST_PERIOD_FLOOR;
			cfg_q.period_ceil  <= RST_PERIOD_CEIL;
			cfg_q.fine_step    <= RST_FINE_STEP;
			cfg_q.coarse_step  <= RST_COARSE_STEP;
			cfg_q.save_delay   <= RST_SAVE_DELAY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PULSE_FLOOR:  cfg_q.pulse_floor  <= cfg_wdata[STEP_W-1:0];
				REG_PULSE_CEIL:   cfg_q.pulse_ceil   <= cfg_wdata[OUT_TIME_W-1:0];
				REG_PERIOD_FLOOR: cfg_q.period_floor <= cfg_wdata[OUT_TIME_W-1:0];
				REG_PERIOD_CEIL:  cfg_q.period_ceil  <= cfg_wdata[OUT_TIME_W-1:0];
				REG_FINE_STEP:    cfg_q.fine_step    <= cfg_wdata[STEP_W-1:0];
				REG_COARSE_STEP:  cfg_q.coarse_step  <= cfg_wdata[STEP_W-1:0];
				REG_SAVE_DELAY:   cfg_q.save_delay   <= cfg_wdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/pse_edit_core.sv =====
module pse_edit_core import pse_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             step,
	input  logic [KEY_W-1:0] key_code,
	output result_t          res
);

	localparam int TW = TIME_BITS + 1;

	logic [TIME_BITS-1:0] pw_q, pl_q, pw2_q;
	logic [STEP_W-1:0]    step_q;
	logic [SEL_W-1:0]     sel_q;
	logic [KEY_W-1:0]     last_q;
	logic [STEP_W-1:0]    cnt_q;

	logic [TIME_BITS-1:0] pw_d, pl_d, pw2_d;
	logic [STEP_W-1:0]    step_d;
	logic [SEL_W-1:0]     sel_d;
	logic [STEP_W-1:0]    cnt_d, cnt_ld;
	logic                 changed, strobe;

	logic [TW-1:0]        pw_x, pl_x, pw2_x, st_x, min_p_x, max_p_x, min_per_x, max_per_x;
	logic [TW-1:0]        pw_up, pl_up, pw2_up;
	logic [TIME_BITS-1:0] st_t, min_p_t, pl_dn, lim;
	logic [STEP_W-1:0]    step_toggle;

	// Operands widened by one bit so that value plus step never wraps.
	always_comb begin
		pw_x      = TW'(pw_q);
		pl_x      = TW'(pl_q);
		pw2_x     = TW'(pw2_q);
		st_x      = TW'(step_q);
		min_p_x   = TW'(cfg.pulse_floor);
		max_p_x   = TW'(cfg.pulse_ceil);
		min_per_x = TW'(cfg.period_floor);
		max_per_x = TW'(cfg.period_ceil);
		pw_up     = pw_x + st_x;
		pl_up     = pl_x + st_x;
		pw2_up    = pw2_x + st_x;
		st_t      = TIME_BITS'(step_q);
		min_p_t   = TIME_BITS'(cfg.pulse_floor);
		pl_dn     = pl_q - st_t;
		lim       = (pl_dn >= min_p_t) ? (pl_dn - min_p_t) : '0;
		step_toggle = (step_q == cfg.fine_step) ? cfg.coarse_step : cfg.fine_step;
	end

	// Key decode and the edit of the selected setting.
	always_comb begin
		pw_d    = pw_q;
		pl_d    = pl_q;
		pw2_d   = pw2_q;
		step_d  = step_q;
		sel_d   = sel_q;
		changed = 1'b0;
		if (key_code != last_q) begin
			case (key_code)
				KEY_DOWN: begin
					case (sel_q)
						SEL_PULSE: begin
							if (pw_x > min_p_x + st_x) begin
								pw_d    = pw_q - st_t;
								changed = 1'b1;
							end
						end
						SEL_PERIOD: begin
							if (pl_x > min_per_x + st_x) begin
								pl_d    = pl_dn;
								pw_d    = (pw_q >= lim) ? lim : pw_q;
								pw2_d   = (pw2_q >= lim) ? lim : pw2_q;
								changed = 1'b1;
							end
						end
						SEL_PULSE2: begin
							if (pw2_x > min_p_x + st_x) begin
								pw2_d   = pw2_q - st_t;
								changed = 1'b1;
							end
						end
						default: step_d = step_toggle;
					endcase
				end
				KEY_UP: begin
					case (sel_q)
						SEL_PULSE: begin
							if (pw_up < max_p_x && pw_up < pl_x) begin
								pw_d    = pw_up[TIME_BITS-1:0];
								changed = 1'b1;
							end
						end
						SEL_PERIOD: begin
							if (pl_up < max_per_x) begin
								pl_d    = pl_up[TIME_BITS-1:0];
								changed = 1'b1;
							end
						end
						SEL_PULSE2: begin
							if (pw2_up < max_p_x && pw2_up < pl_x) begin
								pw2_d   = pw2_up[TIME_BITS-1:0];
								changed = 1'b1;
							end
						end
						default: step_d = step_toggle;
					endcase
				end
				KEY_PREV: sel_d = sel_q - 1'b1;
				KEY_NEXT: sel_d = sel_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Save countdown: reload on a change, then count down to the strobe.
	always_comb begin
		cnt_ld = changed ? cfg.save_delay : cnt_q;
		cnt_d  = (cnt_ld != '0) ? (cnt_ld - 1'b1) : '0;
		strobe = (cnt_ld == STEP_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_q   <= TIME_BITS'(RST_PULSE);
			pl_q   <= TIME_BITS'(RST_PERIOD);
			pw2_q  <= TIME_BITS'(RST_PULSE2);
			step_q <= RST_FINE_STEP;
			sel_q  <= SEL_PULSE;
			last_q <= KEY_NONE;
			cnt_q  <= '0;
		end else if (step) begin
			pw_q   <= pw_d;
			pl_q   <= pl_d;
			pw2_q  <= pw2_d;
			step_q <= step_d;
			sel_q  <= sel_d;
			last_q <= key_code;
			cnt_q  <= cnt_d;
		end
	end

	// Result word shows the settings after this poll.
	always_comb begin
		res.pulse_ns       = pw_d[OUT_TIME_W-1:0];
		res.period_ns      = pl_d[OUT_TIME_W-1:0];
		res.pulse2_ns      = pw2_d[OUT_TIME_W-1:0];
		res.step_ns        = step_d;
		res.selected_field = sel_d;
		res.values_changed = changed;
		res.save_strobe    = strobe;
	end

endmodule

// ===== rtl/pulse_setting_editor_unit.sv =====
// Pulse setting editor. Each key word on the key channel is one poll of the
// front-panel keys; a key acts only when its code differs from the previous
// poll. Every poll returns exactly one settings word with the first pulse,
// period, second pulse, step, selected field, a change flag and a save strobe.
// A poll passes through an input register and is decoded combinationally
// against the stored settings into the output register, so one poll per clock
// is sustained while the settings channel is not stalled. The configuration
// port should be written only while no poll is in flight.
module pulse_setting_editor_unit import pse_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	pse_key_if.sink               key,
	pse_set_if.source             settings
);

	cfg_t             cfg;
	result_t          res;
	result_t          out_q;
	logic             out_v_q;
	logic             valid_s1;
	logic [KEY_W-1:0] key_s1;
	logic             adv;

	pse_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pse_edit_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.step     (adv),
		.key_code (key_s1),
		.res      (res)
	);

	// The registered poll moves on when the output register is free or drains.
	assign adv       = valid_s1 && (!out_v_q || settings.ready);
	assign key.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (key.ready) begin
				valid_s1 <= key.valid;
			end
			if (!out_v_q || settings.ready) begin
				out_v_q <= valid_s1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (key.valid && key.ready) begin
			key_s1 <= key.key_code;
		end
		if (adv) begin
			out_q <= res;
		end
	end

	assign settings.valid          = out_v_q;
	assign settings.pulse_ns       = out_q.pulse_ns;
	assign settings.period_ns      = out_q.period_ns;
	assign settings.pulse2_ns      = out_q.pulse2_ns;
	assign settings.step_ns        = out_q.step_ns;
	assign settings.selected_field = out_q.selected_field;
	assign settings.values_changed = out_q.values_changed;
	assign settings.save_strobe    = out_q.save_strobe;

`ifndef ASSERT_OFF
	// Input stalls only when both stages hold a word and the output is blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!key.ready |-> (valid_s1 && out_v_q && !settings.ready))
		else $error("key channel stalled without a blocked output");

	// A poll that leaves the input register lands in the output register.
	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_v_q)
		else $error("advanced poll did not reach the output register");

	// The step field never reports a value change.
	a_step_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && settings.values_changed) |-> (settings.selected_field != SEL_STEP))
		else $error("value change reported with the step field selected");
`endif

endmodule

// ===== verif/pulse_setting_editor_unit_tb.sv =====
module pulse_setting_editor_unit_tb;
	import pse_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SQUEEZE_LEN  = 120;
	localparam int SQUEEZE_AT   = 200;

	logic clk;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pse_key_if key_ch ();
	pse_set_if set_ch ();

	pulse_setting_editor_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.key       (key_ch),
		.settings  (set_ch)
	);

	// Shadow copy of the registers and of the edited settings.
	cfg_t                  shadow_cfg;
	logic [OUT_TIME_W-1:0] cur_pulse;
	logic [OUT_TIME_W-1:0] cur_period;
	logic [OUT_TIME_W-1:0] cur_pulse2;
	logic [STEP_W-1:0]     cur_step;
	logic [SEL_W-1:0]      cur_sel;
	logic [KEY_W-1:0]      prev_key;
	logic [STEP_W-1:0]     save_count;

	result_t expected_settings[$];

	int  mismatch_count = 0;
	int  polls_sent = 0;
	int  words_seen = 0;
	int  cycles = 0;
	bit  tail_quiet = 0;
	bit  src_calm = 0;
	bit  squeeze_req = 0;
	bit  squeeze_active = 0;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		bit                    typed;
		result_t               want;
	} poll_row_t;

	poll_row_t directed_rows[$];

	always #CLK_HALF clk = ~clk;

	// One line per mismatch, and a running count.
	task automatic flag_mismatch(input string what, input longint unsigned got,
		input longint unsigned want_v);
		mismatch_count++;
		$display("word %0d: %s got %0d, expected %0d", words_seen, what, got, want_v);
	endtask

	// Computes the settings word that one key poll produces and advances the shadow state.
	function automatic result_t edit_settings(input logic [KEY_W-1:0] k);
		longint                pw, pd, p2, st;
		logic [OUT_TIME_W-1:0] lim;
		logic                  changed;
		logic                  strobe;
		result_t               r;
		pw = longint'(cur_pulse);
		pd = longint'(cur_period);
		p2 = longint'(cur_pulse2);
		st = longint'(cur_step);
		changed = 1'b0;
		strobe = 1'b0;
		if (k != prev_key) begin
			case (k)
				KEY_DOWN: begin
					case (cur_sel)
						SEL_PULSE: if (pw > longint'(shadow_cfg.pulse_floor) + st) begin
							cur_pulse = cur_pulse - cur_step;
							changed = 1'b1;
						end
						SEL_PERIOD: if (pd > longint'(shadow_cfg.period_floor) + st) begin
							cur_period = cur_period - cur_step;
							// A shorter period pulls both pulses under its margin.
							if (cur_period >= shadow_cfg.pulse_floor)
								lim = cur_period - shadow_cfg.pulse_floor;
							else
								lim = '0;
							if (cur_pulse >= lim) cur_pulse = lim;
							if (cur_pulse2 >= lim) cur_pulse2 = lim;
							changed = 1'b1;
						end
						SEL_PULSE2: if (p2 > longint'(shadow_cfg.pulse_floor) + st) begin
							cur_pulse2 = cur_pulse2 - cur_step;
							changed = 1'b1;
						end
						default: cur_step = (cur_step == shadow_cfg.fine_step) ?
							shadow_cfg.coarse_step : shadow_cfg.fine_step;
					endcase
				end
				KEY_UP: begin
					case (cur_sel)
						SEL_PULSE: if (pw < longint'(shadow_cfg.pulse_ceil) - st &&
							pw < pd - st) begin
							cur_pulse = cur_pulse + cur_step;
							changed = 1'b1;
						end
						SEL_PERIOD: if (pd < longint'(shadow_cfg.period_ceil) - st) begin
							cur_period = cur_period + cur_step;
							changed = 1'b1;
						end
						SEL_PULSE2: if (p2 < longint'(shadow_cfg.pulse_ceil) - st &&
							p2 < pd - st) begin
							cur_pulse2 = cur_pulse2 + cur_step;
							changed = 1'b1;
						end
						default: cur_step = (cur_step == shadow_cfg.fine_step) ?
							shadow_cfg.coarse_step : shadow_cfg.fine_step;
					endcase
				end
				KEY_PREV: cur_sel = cur_sel - 1'b1;
				KEY_NEXT: cur_sel = cur_sel + 1'b1;
				default: ;
			endcase
		end
		prev_key = k;
		// The save countdown restarts on every change and strobes when it runs out.
		if (changed) save_count = shadow_cfg.save_delay;
		if (save_count != '0) begin
			save_count = save_count - 1'b1;
			if (save_count == '0) strobe = 1'b1;
		end
		r.pulse_ns       = cur_pulse;
		r.period_ns      = cur_period;
		r.pulse2_ns      = cur_pulse2;
		r.step_ns        = cur_step;
		r.selected_field = cur_sel;
		r.values_changed = changed;
		r.save_strobe    = strobe;
		return r;
	endfunction

	// Offers one key word, records its settings word once taken, then maybe idles.
	task automatic send_key(input logic [KEY_W-1:0] k, input bit typed, input result_t want);
		result_t got;
		key_ch.valid <= 1'b1;
		key_ch.key_code <= k;
		do @(posedge clk); while (!key_ch.ready);
		got = edit_settings(k);
		expected_settings.push_back(typed ? want : got);
		polls_sent++;
		// The long receiver hold-off starts while keys keep coming.
		if (polls_sent == SQUEEZE_AT) squeeze_req = 1'b1;
		if (polls_sent % 60 == 0) src_calm = ($urandom_range(0, 2) == 0);
		if (!tail_quiet && !squeeze_active && !src_calm && $urandom_range(0, 4) == 0) begin
			key_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Stops offering keys and waits until every settings word has come back.
	task automatic drain_polls();
		key_ch.valid <= 1'b0;
		while (expected_settings.size() != 0) @(posedge clk);
	endtask

	// Writes one register; the caller lowers the write enable after a batch.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_PULSE_FLOOR:  shadow_cfg.pulse_floor  = val[STEP_W-1:0];
			REG_PULSE_CEIL:   shadow_cfg.pulse_ceil   = val;
			REG_PERIOD_FLOOR: shadow_cfg.period_floor = val;
			REG_PERIOD_CEIL:  shadow_cfg.period_ceil  = val;
			REG_FINE_STEP:    shadow_cfg.fine_step    = val[STEP_W-1:0];
			REG_COARSE_STEP:  shadow_cfg.coarse_step  = val[STEP_W-1:0];
			REG_SAVE_DELAY:   shadow_cfg.save_delay   = val[STEP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic add_poll(input logic [KEY_W-1:0] k);
		poll_row_t row;
		row.is_cfg = 1'b0;
		row.idx = '0;
		row.val = CFG_DATA_W'(k);
		row.typed = 1'b0;
		row.want = '0;
		directed_rows.push_back(row);
	endtask

	task automatic add_typed(input logic [KEY_W-1:0] k, input int p, input int per, input int p2,
		input int st, input logic [SEL_W-1:0] sel, input bit ch, input bit sb);
		poll_row_t row;
		row.is_cfg = 1'b0;
		row.idx = '0;
		row.val = CFG_DATA_W'(k);
		row.typed = 1'b1;
		row.want.pulse_ns = OUT_TIME_W'(p);
		row.want.period_ns = OUT_TIME_W'(per);
		row.want.pulse2_ns = OUT_TIME_W'(p2);
		row.want.step_ns = STEP_W'(st);
		row.want.selected_field = sel;
		row.want.values_changed = ch;
		row.want.save_strobe = sb;
		directed_rows.push_back(row);
	endtask

	task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input int v);
		poll_row_t row;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.val = CFG_DATA_W'(v);
		row.typed = 1'b0;
		row.want = '0;
		directed_rows.push_back(row);
	endtask

	// One setting of all registers followed by random key traffic.
	task automatic run_phase(input int unsigned mnp, input int unsigned mxp,
		input int unsigned mnd, input int unsigned mxd, input int unsigned fs,
		input int unsigned cs, input int unsigned sd, input int n_polls);
		int               target;
		int unsigned      pick;
		logic [KEY_W-1:0] k;
		drain_polls();
		write_reg(REG_PULSE_FLOOR, CFG_DATA_W'(mnp));
		write_reg(REG_PULSE_CEIL, CFG_DATA_W'(mxp));
		write_reg(REG_PERIOD_FLOOR, CFG_DATA_W'(mnd));
		write_reg(REG_PERIOD_CEIL, CFG_DATA_W'(mxd));
		write_reg(REG_FINE_STEP, CFG_DATA_W'(fs));
		write_reg(REG_COARSE_STEP, CFG_DATA_W'(cs));
		write_reg(REG_SAVE_DELAY, CFG_DATA_W'(sd));
		cfg_we <= 1'b0;
		target = polls_sent + n_polls;
		while (polls_sent < target) begin
			// Mostly clean press and release sequences, with some raw noise.
			if ($urandom_range(0, 99) < 85) begin
				pick = $urandom_range(0, 99);
				k = (pick < 35) ? KEY_DOWN : (pick < 70) ? KEY_UP :
					(pick < 85) ? KEY_PREV : KEY_NEXT;
				repeat ($urandom_range(1, 3)) send_key(k, 1'b0, '0);
				repeat ($urandom_range(1, 2)) send_key(KEY_NONE, 1'b0, '0);
			end else begin
				send_key(KEY_W'($urandom_range(0, 7)), 1'b0, '0);
			end
		end
	endtask

	// Receiver: random stalls, one long hold-off, and none near the end.
	initial begin
		bit sink_calm;
		sink_calm = 1'b0;
		set_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (cycles % 500 == 0) sink_calm = ($urandom_range(0, 2) == 0);
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				squeeze_active = 1'b1;
				set_ch.ready <= 1'b0;
				repeat (SQUEEZE_LEN) @(posedge clk);
				squeeze_active = 1'b0;
			end else if (!tail_quiet && !sink_calm && $urandom_range(0, 5) == 0) begin
				set_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			set_ch.ready <= 1'b1;
		end
	end

	// Compares each settings word against the oldest expectation.
	always @(posedge clk) begin : settings_check
		result_t want;
		if (arst_n && set_ch.valid && set_ch.ready) begin
			if (expected_settings.size() == 0) begin
				flag_mismatch("unexpected word, pulse_ns", 64'(set_ch.pulse_ns), 0);
			end else begin
				want = expected_settings.pop_front();
				if (set_ch.pulse_ns !== want.pulse_ns)
					flag_mismatch("pulse_ns", 64'(set_ch.pulse_ns), 64'(want.pulse_ns));
				if (set_ch.period_ns !== want.period_ns)
					flag_mismatch("period_ns", 64'(set_ch.period_ns), 64'(want.period_ns));
				if (set_ch.pulse2_ns !== want.pulse2_ns)
					flag_mismatch("pulse2_ns", 64'(set_ch.pulse2_ns), 64'(want.pulse2_ns));
				if (set_ch.step_ns !== want.step_ns)
					flag_mismatch("step_ns", 64'(set_ch.step_ns), 64'(want.step_ns));
				if (set_ch.selected_field !== want.selected_field)
					flag_mismatch("selected_field", 64'(set_ch.selected_field),
						64'(want.selected_field));
				if (set_ch.values_changed !== want.values_changed)
					flag_mismatch("values_changed", 64'(set_ch.values_changed),
						64'(want.values_changed));
				if (set_ch.save_strobe !== want.save_strobe)
					flag_mismatch("save_strobe", 64'(set_ch.save_strobe),
						64'(want.save_strobe));
			end
			words_seen++;
		end
	end

	// Watchdog.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		bit in_cfg;
		clk = 1'b0;
		arst_n <= 1'b0;
		key_ch.valid <= 1'b0;
		key_ch.key_code <= KEY_NONE;
		cfg_we <= 1'b0;
		cfg_index <= REG_PULSE_FLOOR;
		cfg_wdata <= '0;
		in_cfg = 1'b0;

		// Shadow state as it stands after reset.
		shadow_cfg.pulse_floor  = RST_PULSE_FLOOR;
		shadow_cfg.pulse_ceil   = RST_PULSE_CEIL;
		shadow_cfg.period_floor = RST_PERIOD_FLOOR;
		shadow_cfg.period_ceil  = RST_PERIOD_CEIL;
		shadow_cfg.fine_step    = RST_FINE_STEP;
		shadow_cfg.coarse_step  = RST_COARSE_STEP;
		shadow_cfg.save_delay   = RST_SAVE_DELAY;
		cur_pulse  = OUT_TIME_W'(RST_PULSE);
		cur_period = OUT_TIME_W'(RST_PERIOD);
		cur_pulse2 = OUT_TIME_W'(RST_PULSE2);
		cur_step   = RST_FINE_STEP;
		cur_sel    = SEL_PULSE;
		prev_key   = KEY_NONE;
		save_count = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: every key on every field, wrap of the selection, repeated and
		// unused codes, zero and one poll save delay, period shrink with and without a
		// negative margin, and moves blocked by a zero pulse ceiling.
		add_typed(KEY_NONE, 1000, 50000, 2000, 100, SEL_PULSE, 0, 0);
		add_typed(KEY_UP, 1100, 50000, 2000, 100, SEL_PULSE, 1, 0);
		add_typed(KEY_UP, 1100, 50000, 2000, 100, SEL_PULSE, 0, 0);
		add_poll(KEY_DOWN);
		add_poll(KEY_NEXT);
		add_poll(KEY_DOWN);
		add_poll(KEY_UP);
		add_poll(KEY_NEXT);
		add_poll(KEY_UP);
		add_poll(KEY_DOWN);
		add_poll(KEY_NEXT);
		add_poll(KEY_UP);
		add_poll(KEY_DOWN);
		add_poll(KEY_NEXT);
		add_poll(KEY_PREV);
		add_poll(3'd5);
		add_typed(3'd7, 1000, 50000, 2000, 100, SEL_STEP, 0, 0);
		add_cfg(REG_SAVE_DELAY, 0);
		add_poll(KEY_PREV);
		add_typed(KEY_UP, 1000, 50000, 2100, 100, SEL_PULSE2, 1, 0);
		add_cfg(REG_SAVE_DELAY, 1);
		add_typed(KEY_DOWN, 1000, 50000, 2000, 100, SEL_PULSE2, 1, 1);
		add_cfg(REG_PULSE_FLOOR, 49000);
		add_poll(KEY_PREV);
		add_typed(KEY_DOWN, 900, 49900, 900, 100, SEL_PERIOD, 1, 1);
		add_cfg(REG_PULSE_FLOOR, 65535);
		add_poll(KEY_UP);
		add_typed(KEY_DOWN, 0, 49900, 0, 100, SEL_PERIOD, 1, 1);
		add_cfg(REG_PULSE_CEIL, 0);
		add_cfg(REG_SAVE_DELAY, 2);
		add_poll(KEY_NEXT);
		add_typed(KEY_UP, 0, 49900, 0, 100, SEL_PULSE2, 0, 0);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				if (!in_cfg) drain_polls();
				in_cfg = 1'b1;
				write_reg(directed_rows[i].idx, directed_rows[i].val);
			end else begin
				if (in_cfg) cfg_we <= 1'b0;
				in_cfg = 1'b0;
				send_key(directed_rows[i].val[KEY_W-1:0], directed_rows[i].typed,
					directed_rows[i].want);
			end
		end

		// Random part over several register settings, extremes included.
		run_phase(32'(RST_PULSE_FLOOR), 32'(RST_PULSE_CEIL), 32'(RST_PERIOD_FLOOR),
			32'(RST_PERIOD_CEIL), 32'(RST_FINE_STEP), 32'(RST_COARSE_STEP), 2, 100);
		run_phase(0, 131071, 0, 131071, 1, 65535, 1, 130);
		run_phase(65535, 0, 131071, 0, 65535, 1, 65535, 50);
		run_phase(3000, 30000, 4000, 30000, 500, 4000, 3, 150);
		run_phase($urandom_range(0, 131071), $urandom_range(0, 131071),
			$urandom_range(0, 131071), $urandom_range(0, 131071),
			$urandom_range(0, 131071), $urandom_range(0, 131071),
			$urandom_range(0, 6), 140);
		tail_quiet = 1'b1;
		run_phase($urandom_range(0, 2000), $urandom_range(20000, 131071),
			$urandom_range(0, 20000), $urandom_range(20000, 131071),
			$urandom_range(1, 300), $urandom_range(1, 5000),
			$urandom_range(0, 4), 110);

		drain_polls();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
